// ===== rtl/sdh_pkg.sv =====
`default_nettype none
package sdh_pkg;
    localparam int unsigned HistoryDepth = 512;
    localparam int unsigned AddrW = $clog2(HistoryDepth);
    localparam int unsigned CountW = $clog2(HistoryDepth + 1);
    localparam int unsigned EntryW = 96;
    localparam logic [15:0] DedupReset = 16'd150;
    localparam logic [16:0] PrimaryReset = 17'h1FFFF;
    localparam logic [7:0] MeterReset = 8'd1;

    localparam logic [1:0] RegDedup = 2'd0;
    localparam logic [1:0] RegPrimary = 2'd1;
    localparam logic [1:0] RegMeter = 2'd2;

    localparam logic [1:0] StInserted = 2'd0;
    localparam logic [1:0] StDuplicate = 2'd1;
    localparam logic [1:0] StTooOld = 2'd2;

    typedef struct packed {
        logic [7:0] kind;
        logic [15:0] source;
        logic [15:0] trend;
        logic [15:0] glucose;
        logic [39:0] stamp;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_DUP_RD, S_DUP_CHK, S_OLD_CHK, S_SH_RD, S_SH_CHK,
        S_PUT, S_CUR_RD, S_CUR_CHK, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic rd_prev;
        logic wr_shift;
        logic wr_new;
        logic set_idx_zero;
        logic set_idx_last;
        logic idx_inc;
        logic idx_dec;
        logic count_inc;
        logic set_status;
        logic [1:0] status;
        logic cur_hit;
        logic cur_none;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic idx_zero;
        logic dup_hit;
        logic full;
        logic too_old;
        logic shift_more;
        logic cur_match;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/sorted_dedup_history_insert.sv =====
`default_nettype none
// Each transaction runs serial scans over the one-port entry memory: the duplicate
// scan, the insertion shift (only when the reading is inserted) and the current scan.
// One transaction is processed at a time; a new one is accepted once the result is taken.
// Synchronous active-low reset empties the table and restores the register defaults.
// Memory contents are not cleared; the fill count guards every read.
module sorted_dedup_history_insert (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // stamp, glucose, trend_value, source_id
    input  wire logic [87:0] s_axis_tdata,
    // reading_kind
    input  wire logic [7:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, current_glucose, current_trend, current_stamp, zero fill
    output logic [79:0]      m_axis_tdata
);
    import sdh_pkg::*;

    t_cmd w_cmd;
    t_stat w_stat;
    logic [1:0] w_status;
    logic [15:0] w_glu;
    logic [15:0] w_tr;
    logic [39:0] w_st;

    sdh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    sdh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_data({s_axis_tuser, s_axis_tdata}), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_status(w_status), .o_glucose(w_glu), .o_trend(w_tr), .o_stamp(w_st)
    );

    assign m_axis_tdata = {6'd0, w_st, w_tr, w_glu, w_status};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
    a_cmd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_shift && w_cmd.wr_new)) else $error("double write");
endmodule
`default_nettype wire

// ===== rtl/sdh_ctrl.sv =====
`default_nettype none
module sdh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sdh_pkg::t_stat i_stat,
    output sdh_pkg::t_cmd      o_cmd
);
    import sdh_pkg::*;

    t_state r_state, n_state;
    logic r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_valid;
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    o_cmd.set_idx_zero = 1'b1;
                    n_state = S_DUP_RD;
                end
            end
            S_DUP_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_OLD_CHK;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_DUP_CHK;
                end
            end
            S_DUP_CHK: begin
                if (i_stat.dup_hit) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = StDuplicate;
                    o_cmd.set_idx_zero = 1'b1;
                    n_state = S_CUR_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_DUP_RD;
                end
            end
            S_OLD_CHK: begin
                if (i_stat.too_old) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = StTooOld;
                    o_cmd.set_idx_zero = 1'b1;
                    n_state = S_CUR_RD;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = StInserted;
                    o_cmd.count_inc = !i_stat.full;
                    o_cmd.set_idx_last = 1'b1;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_stat.idx_zero) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                if (i_stat.shift_more) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.idx_dec = 1'b1;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.wr_new = 1'b1;
                o_cmd.set_idx_zero = 1'b1;
                n_state = S_CUR_RD;
            end
            S_CUR_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.cur_none = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_CUR_CHK;
                end
            end
            S_CUR_CHK: begin
                if (i_stat.cur_match) begin
                    o_cmd.cur_hit = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CUR_RD;
                end
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/sdh_datapath.sv =====
`default_nettype none
module sdh_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data,
    input  wire logic [95:0]   i_in_data,
    input  wire sdh_pkg::t_cmd i_cmd,
    output sdh_pkg::t_stat     o_stat,
    output logic [1:0]         o_status,
    output logic [15:0]        o_glucose,
    output logic [15:0]        o_trend,
    output logic [39:0]        o_stamp
);
    import sdh_pkg::*;

    t_entry r_mem [HistoryDepth];
    t_entry r_rd;
    t_entry r_item;
    t_entry w_new;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] r_idx;
    logic [AddrW-1:0] w_addr;
    logic [AddrW-1:0] w_rd_addr;
    logic [15:0] r_dedup;
    logic [16:0] r_primary;
    logic [7:0] r_meter;
    logic [1:0] r_status;
    logic [15:0] r_glu;
    logic [15:0] r_tr;
    logic [39:0] r_st;
    logic [39:0] w_diff;
    logic [39:0] w_win;
    logic w_full;

    assign w_new = t_entry'(i_in_data);
    assign w_addr = r_idx[AddrW-1:0];
    assign w_rd_addr = i_cmd.rd_prev ? w_addr - AddrW'(1) : w_addr;
    assign w_full = (r_count == CountW'(HistoryDepth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup <= DedupReset;
            r_primary <= PrimaryReset;
            r_meter <= MeterReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegDedup: r_dedup <= i_cfg_data[15:0];
                RegPrimary: r_primary <= i_cfg_data;
                RegMeter: r_meter <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.set_idx_last) begin
            r_idx <= w_full ? r_count - 1'b1 : r_count;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= w_new;
        if (i_cmd.rd) r_rd <= r_mem[w_rd_addr];
        if (i_cmd.wr_shift) r_mem[w_addr] <= r_rd;
        if (i_cmd.wr_new) r_mem[w_addr] <= r_item;
    end

    assign w_diff = (r_item.stamp >= r_rd.stamp) ? r_item.stamp - r_rd.stamp
                                                 : r_rd.stamp - r_item.stamp;
    assign w_win = (r_item.kind == r_meter) ? 40'd0 : {24'd0, r_dedup};

    always_comb begin
        o_stat.idx_end = (r_idx == r_count);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.full = w_full;
        o_stat.dup_hit = (r_rd.source == r_item.source) && (r_rd.kind == r_item.kind)
                         && (w_diff <= w_win);
        o_stat.too_old = w_full && (r_item.stamp <= r_rd.stamp);
        o_stat.shift_more = (r_rd.stamp < r_item.stamp)
                            || ((r_rd.stamp == r_item.stamp) && (r_rd.source > r_item.source));
        o_stat.cur_match = (r_rd.kind != r_meter)
                           && (r_primary[16] || (r_primary[15:0] == r_rd.source));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) r_status <= i_cmd.status;
        if (i_cmd.cur_hit) begin
            r_glu <= r_rd.glucose;
            r_tr <= r_rd.trend;
            r_st <= r_rd.stamp;
        end else if (i_cmd.cur_none) begin
            r_glu <= 16'hFFFF;
            r_tr <= '0;
            r_st <= '0;
        end
    end

    assign o_status = r_status;
    assign o_glucose = r_glu;
    assign o_trend = r_tr;
    assign o_stamp = r_st;
endmodule
`default_nettype wire

// ===== bench/sorted_dedup_history_insert_tb.sv =====
`default_nettype none
module sorted_dedup_history_insert_tb;
    import sdh_pkg::*;

    localparam int Depth = HistoryDepth;
    localparam int RandomItems = 560;
    localparam longint CycleLimit = 64'd20000000;

    typedef struct packed {
        logic [7:0] kind;
        logic [15:0] source;
        logic [15:0] trend;
        logic [15:0] glucose;
        logic [39:0] stamp;
    } t_reading;

    typedef struct packed {
        logic [39:0] stamp;
        logic [15:0] trend;
        logic [15:0] glucose;
        logic [1:0] status;
    } t_report;

    typedef struct {
        t_reading rd;
        logic check_fixed;
        t_report fixed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [7:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    sorted_dedup_history_insert DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_reading hist[Depth];
    int hist_count;
    logic [15:0] win_reg;
    logic [16:0] primary_reg;
    logic [7:0] meter_reg;

    t_report pending_reports[$];
    t_report fixed_reports[$];
    logic fixed_flags[$];
    int errors = 0;
    longint cycles = 0;
    int hold_off = 0;
    logic stim_done = 1'b0;

    t_row rows[$];

    function automatic t_report insert_reading(t_reading r);
        t_report rep;
        logic [39:0] span;
        logic [39:0] lim;
        int i;
        logic dup;
        logic any_src;
        dup = 1'b0;
        lim = (r.kind == meter_reg) ? 40'd0 : {24'd0, win_reg};
        for (i = 0; i < hist_count; i++) begin
            if (hist[i].source == r.source && hist[i].kind == r.kind) begin
                span = (r.stamp >= hist[i].stamp) ? r.stamp - hist[i].stamp
                                                  : hist[i].stamp - r.stamp;
                if (span <= lim) dup = 1'b1;
            end
        end
        if (dup) begin
            rep.status = StDuplicate;
        end else if (hist_count >= Depth && r.stamp <= hist[Depth-1].stamp) begin
            rep.status = StTooOld;
        end else begin
            rep.status = StInserted;
            if (hist_count < Depth) hist_count++;
            i = hist_count - 1;
            while (i > 0 && (hist[i-1].stamp < r.stamp ||
                   (hist[i-1].stamp == r.stamp && hist[i-1].source > r.source))) begin
                hist[i] = hist[i-1];
                i--;
            end
            hist[i] = r;
        end
        rep.glucose = 16'hFFFF;
        rep.trend = '0;
        rep.stamp = '0;
        any_src = primary_reg[16];
        for (i = 0; i < hist_count; i++) begin
            if (hist[i].kind != meter_reg &&
                (any_src || {1'b0, hist[i].source} == primary_reg)) begin
                rep.glucose = hist[i].glucose;
                rep.trend = hist[i].trend;
                rep.stamp = hist[i].stamp;
                break;
            end
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("sorted_dedup_history_insert_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        logic fx;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_report'(m_axis_tdata[73:0]);
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, got);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                fx = fixed_flags.pop_front();
                if (fx) want = fixed_reports.pop_front();
                if (got.status !== want.status || got.glucose !== want.glucose ||
                    got.trend !== want.trend || got.stamp !== want.stamp) begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off requested by the sender.
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegDedup) win_reg = val[15:0];
        else if (idx == RegPrimary) primary_reg = val;
        else if (idx == RegMeter) meter_reg = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_reading(t_reading r, logic fx, t_report fv, logic gap);
        int w;
        w = gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7)) : 0;
        if (w > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r[87:0];
        s_axis_tuser <= r.kind;
        pending_reports.push_back(insert_reading(r));
        fixed_flags.push_back(fx);
        if (fx) fixed_reports.push_back(fv);
        @(posedge i_clk iff s_axis_tready);
    endtask

    function automatic t_reading rand_reading(logic [39:0] base, int nsrc);
        t_reading r;
        r.stamp = base + 40'($urandom_range(0, 400));
        r.glucose = 16'($urandom);
        r.trend = 16'($urandom);
        r.source = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, nsrc));
        r.kind = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        return r;
    endfunction

    function automatic t_row mk(logic [39:0] st, logic [15:0] g, logic [15:0] tr,
                                logic [15:0] src, logic [7:0] k, logic fx,
                                logic [1:0] s, logic [15:0] cg, logic [15:0] ct,
                                logic [39:0] cs);
        t_row row;
        row.rd = '{kind: k, source: src, trend: tr, glucose: g, stamp: st};
        row.check_fixed = fx;
        row.fixed = '{stamp: cs, trend: ct, glucose: cg, status: s};
        return row;
    endfunction

    initial begin
        t_reading r;
        t_report none;
        logic [39:0] clock_s;
        int n;
        none = '0;
        hist_count = 0;
        win_reg = DedupReset;
        primary_reg = PrimaryReset;
        meter_reg = MeterReset;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: a meter reading is stored but never current.
        rows.push_back(mk(40'd1000, 16'd90, 16'd0, 16'd3, 8'd1, 1'b1, StInserted,
                          16'hFFFF, 16'd0, 40'd0));
        rows.push_back(mk(40'd1000, 16'd91, 16'd0, 16'd3, 8'd1, 1'b1, StDuplicate,
                          16'hFFFF, 16'd0, 40'd0));
        rows.push_back(mk(40'd1001, 16'd92, 16'd0, 16'd3, 8'd1, 1'b1, StInserted,
                          16'hFFFF, 16'd0, 40'd0));
        rows.push_back(mk(40'd2000, 16'h7FFF, 16'h8000, 16'd0, 8'd0, 1'b1, StInserted,
                          16'h7FFF, 16'h8000, 40'd2000));
        rows.push_back(mk(40'd2150, 16'd5, 16'd5, 16'd0, 8'd0, 1'b1, StDuplicate,
                          16'h7FFF, 16'h8000, 40'd2000));
        rows.push_back(mk(40'd2151, 16'h8000, 16'h7FFF, 16'd0, 8'd0, 1'b1, StInserted,
                          16'h8000, 16'h7FFF, 40'd2151));
        rows.push_back(mk(40'hFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                          StInserted, 16'hFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF));
        rows.push_back(mk(40'd0, 16'd7, 16'd7, 16'd9, 8'd0, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd2151, 16'd8, 16'd8, 16'd1, 8'd0, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'hFF_FFFF_FFFF, 16'd9, 16'd9, 16'd2, 8'd0, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd2151, 16'd1, 16'd1, 16'd0, 8'd2, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        foreach (rows[k])
            send_reading(rows[k].rd, rows[k].check_fixed, rows[k].fixed, 1'b1);
        wait_drained();

        // Primary source set, window zero, other meter kind.
        write_reg(RegPrimary, 17'd2);
        write_reg(RegDedup, 17'd0);
        write_reg(RegMeter, 17'd0);
        rows.delete();
        rows.push_back(mk(40'd5000, 16'd1, 16'd1, 16'd2, 8'd5, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd5001, 16'd2, 16'd2, 16'd2, 8'd5, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd5001, 16'd3, 16'd3, 16'd2, 8'd5, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd6000, 16'd4, 16'd4, 16'd2, 8'd0, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        rows.push_back(mk(40'd6000, 16'd5, 16'd5, 16'd1, 8'd1, 1'b0, StInserted,
                          16'd0, 16'd0, 40'd0));
        foreach (rows[k]) send_reading(rows[k].rd, 1'b0, none, 1'b1);
        wait_drained();
        write_reg(RegPrimary, 17'h10000);
        write_reg(RegDedup, 17'h0FFFF);
        write_reg(RegMeter, 17'h000FF);
        send_reading('{kind: 8'd0, source: 16'd2, trend: 16'd0, glucose: 16'd0,
                       stamp: 40'd70000}, 1'b0, none, 1'b0);
        wait_drained();
        write_reg(RegPrimary, 17'd65535);
        write_reg(RegDedup, 17'(DedupReset));
        write_reg(RegMeter, 17'(MeterReset));

        // Fill the table past capacity; hold the receiver off for a long stretch first.
        hold_off = 4000;
        clock_s = 40'd100000;
        n = 0;
        for (int j = 0; j < RandomItems; j++) begin
            if (j == 280) begin
                wait_drained();
                case ($urandom_range(0, 2))
                    0: write_reg(RegPrimary, 17'h1FFFF);
                    1: write_reg(RegPrimary, 17'($urandom_range(0, 5)));
                    default: write_reg(RegPrimary, 17'h1FFF0);
                endcase
                write_reg(RegDedup, 17'($urandom_range(0, 300)));
                write_reg(RegMeter, 17'($urandom_range(0, 2)));
            end
            if ($urandom_range(0, 9) < 7) clock_s = clock_s + 40'($urandom_range(1, 200));
            r = rand_reading(clock_s - 40'd200, 30);
            if ($urandom_range(0, 19) == 0) r.stamp = 40'($urandom_range(0, 50000));
            if ($urandom_range(0, 49) == 0) r.stamp = {8'($urandom), 32'($urandom)};
            send_reading(r, 1'b0, none, 1'b1);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        stim_done = 1'b1;
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("sorted_dedup_history_insert_tb OK");
        end else begin
            $display("sorted_dedup_history_insert_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
